FILE: rtl/core/um32_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UM32 package
// Field widths, opcode and action codes shared by the execute unit, divider and testbench.
// ----------------------------------------------------------------------------
package um32_pkg;

  localparam int WordW    = 32;
  localparam int RegAddrW = 3;
  localparam int RegCount = 8;
  localparam int ActW     = 4;
  localparam int OpLsb    = 28;
  localparam int ImmW     = 25;
  localparam int CharLimit = 256;

  typedef logic [WordW-1:0]    word_t;
  typedef logic [RegAddrW-1:0] raddr_t;

  typedef enum logic [3:0] {
    OP_CMOV  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_STORE = 4'd2,
    OP_ADD   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_NAND  = 4'd6,
    OP_HALT  = 4'd7,
    OP_MAP   = 4'd8,
    OP_UNMAP = 4'd9,
    OP_OUT   = 4'd10,
    OP_IN    = 4'd11,
    OP_PROG  = 4'd12,
    OP_IMM   = 4'd13
  } opcode_t;

  typedef enum logic [ActW-1:0] {
    ACT_NONE     = 4'd0,
    ACT_LOAD     = 4'd1,
    ACT_STORE    = 4'd2,
    ACT_MAP      = 4'd3,
    ACT_UNMAP    = 4'd4,
    ACT_OUT      = 4'd5,
    ACT_IN       = 4'd6,
    ACT_PROG     = 4'd7,
    ACT_HALT     = 4'd8,
    ACT_DIVZERO  = 4'd9,
    ACT_ILLEGAL  = 4'd10,
    ACT_REJECTED = 4'd11
  } action_t;

  typedef struct packed {
    logic  mode;
    word_t instr_word;
    word_t response_value;
  } in_item_t;

  typedef struct packed {
    logic [ActW-1:0] action;
    word_t           operand_x;
    word_t           operand_y;
    word_t           operand_z;
  } out_item_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    word_t quotient;
  } div_rsp_t;

endpackage

FILE: rtl/core/um32_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UM32 stream interface
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface um32_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/um32_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UM32 divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module um32_divider
  import um32_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CntW = $clog2(WordW + 1);

  logic [CntW-1:0] count;
  logic            busy;
  logic            done;
  word_t           quo;
  word_t           rem;
  word_t           dsr;
  logic [WordW:0]  trial;

  assign trial = {rem, quo[WordW-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        count <= CntW'(WordW);
        quo   <= req.dividend;
        rem   <= '0;
        dsr   <= req.divisor;
      end else if (busy) begin
        if (trial[WordW]) begin
          rem <= {rem[WordW-2:0], quo[WordW-1]};
          quo <= {quo[WordW-2:0], 1'b0};
        end else begin
          rem <= trial[WordW-1:0];
          quo <= {quo[WordW-2:0], 1'b1};
        end
        count <= count - 1'b1;
        if (count == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !rsp.busy)
    else $error("divider done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (req.start && !busy) |=> busy)
    else $error("divider did not start");
  a_count_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> count != '0)
    else $error("divider count empty while busy");
`endif

endmodule

FILE: rtl/core/um32_register_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UM32 register execute unit
// Executes universal machine instructions against an eight-word register
// file and issues memory, I/O and control requests as result items.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries {mode, instr_word, response_value}; mode 0 is an
//   instruction, mode 1 returns the value of a load, map or input request
//   to the pending target register.
//   out_ch carries {action, operand_x, operand_y, operand_z}, one item for
//   every input item, in order.
// Timing:
//   An item is read from the register file (synchronous memory, three read
//   ports) as it is taken, then executed and written back. A divide then
//   waits in S_DIV for the bit-serial divider. The result lands in an output
//   register; the next item is taken once that register is empty or being
//   drained and the unit is idle, so no item enters before the last is done.
// Reset:
//   rst clears the register file in a sweep, one entry a cycle, and
//   clears the pending response state. No item is taken during the sweep.
// Stall:
//   While out_ch is stalled the held result stays and no new item enters.
// ----------------------------------------------------------------------------
module um32_register_execute_unit
  import um32_pkg::*;
(
  input  logic clk,
  input  logic rst,
  um32_stream_if.sink   in_ch,
  um32_stream_if.source out_ch
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_DIV
  } state_t;

  state_t    state;
  raddr_t    clr_addr;
  in_item_t  item;
  word_t     regs [RegCount];
  word_t     rd_b;
  word_t     rd_c;
  word_t     rd_a;
  logic      awaiting;
  raddr_t    pending;
  out_item_t result;
  logic      out_valid;
  logic      wr_en;
  raddr_t    wr_addr;
  word_t     wr_data;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  logic [3:0] op;
  raddr_t     fa;
  raddr_t     fb;
  raddr_t     fc;
  raddr_t     in_a;
  raddr_t     in_b;
  raddr_t     in_c;
  word_t      product;
  logic       accept;
  logic       out_free;
  out_item_t  exec_res;
  logic       exec_div;
  logic       set_wait;
  raddr_t     wait_tgt;

  assign op   = item.instr_word[WordW-1:OpLsb];
  assign fa   = item.instr_word[8:6];
  assign fb   = item.instr_word[5:3];
  assign fc   = item.instr_word[2:0];
  assign in_a = in_ch.payload.instr_word[8:6];
  assign in_b = in_ch.payload.instr_word[5:3];
  assign in_c = in_ch.payload.instr_word[2:0];

  assign out_free    = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a <= regs[in_a];
      rd_b <= regs[in_b];
      rd_c <= regs[in_c];
    end
    if (wr_en) begin
      regs[wr_addr] <= wr_data;
    end
  end

  assign product = WordW'(rd_b * rd_c);

  assign div_req.start    = (state == S_EXEC) && exec_div;
  assign div_req.dividend = rd_b;
  assign div_req.divisor  = rd_c;

  um32_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fa;
    wr_data = '0;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
    end else if (state == S_DIV) begin
      wr_en   = div_rsp.done;
      wr_data = div_rsp.quotient;
    end else if (state == S_EXEC) begin
      if (item.mode) begin
        wr_en   = awaiting;
        wr_addr = pending;
        wr_data = item.response_value;
      end else if (!awaiting) begin
        case (op)
          OP_CMOV: begin
            wr_en   = (rd_c != '0);
            wr_data = rd_b;
          end
          OP_ADD: begin
            wr_en   = 1'b1;
            wr_data = rd_b + rd_c;
          end
          OP_MUL: begin
            wr_en   = 1'b1;
            wr_data = product;
          end
          OP_NAND: begin
            wr_en   = 1'b1;
            wr_data = ~(rd_b & rd_c);
          end
          OP_IMM: begin
            wr_en   = 1'b1;
            wr_addr = item.instr_word[ImmW+RegAddrW-1:ImmW];
            wr_data = WordW'(item.instr_word[ImmW-1:0]);
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    exec_res = '0;
    exec_div = 1'b0;
    set_wait = 1'b0;
    wait_tgt = fa;
    if (!item.mode) begin
      if (awaiting) begin
        exec_res.action = ACT_REJECTED;
      end else begin
        case (op)
          OP_LOAD: begin
            exec_res = '{ACT_LOAD, rd_b, rd_c, '0};
            set_wait = 1'b1;
            wait_tgt = fa;
          end
          OP_STORE: exec_res = '{ACT_STORE, rd_a, rd_b, rd_c};
          OP_DIV: begin
            if (rd_c == '0) begin
              exec_res.action = ACT_DIVZERO;
            end else begin
              exec_div = 1'b1;
            end
          end
          OP_HALT: exec_res.action = ACT_HALT;
          OP_MAP: begin
            exec_res = '{ACT_MAP, rd_c, '0, '0};
            set_wait = 1'b1;
            wait_tgt = fb;
          end
          OP_UNMAP: exec_res = '{ACT_UNMAP, rd_c, '0, '0};
          OP_OUT: begin
            if (rd_c < WordW'(CharLimit)) begin
              exec_res = '{ACT_OUT, rd_c, '0, '0};
            end
          end
          OP_IN: begin
            exec_res.action = ACT_IN;
            set_wait = 1'b1;
            wait_tgt = fc;
          end
          OP_PROG: exec_res = '{ACT_PROG, rd_b, rd_c, '0};
          OP_CMOV, OP_ADD, OP_MUL, OP_NAND, OP_IMM: exec_res.action = ACT_NONE;
          default: exec_res.action = ACT_ILLEGAL;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      awaiting  <= 1'b0;
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (((state == S_EXEC) && !exec_div) || ((state == S_DIV) && div_rsp.done)) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == raddr_t'(RegCount - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item  <= in_ch.payload;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          result <= exec_res;
          if (item.mode) begin
            awaiting <= 1'b0;
          end else if (set_wait) begin
            awaiting <= 1'b1;
            pending  <= wait_tgt;
          end
          if (exec_div) begin
            state <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.payload = result;

`ifndef SYNTHESIS
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ch.ready)
    else $error("item taken during clear");
  a_exec_yields: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |=> (out_valid || state == S_DIV))
    else $error("exec produced no result");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> out_valid && $stable(result))
    else $error("result changed while stalled");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |=> state == S_DIV)
    else $error("divide not tracked");
`endif

endmodule

FILE: test/um32_exec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UM32 execute unit checker
// Watches the input and output channels, runs its own copy of the register
// file and pending-response state for each accepted item, and compares every
// accepted result field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module um32_exec_checker
  import um32_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        errors,
  output int        outstanding
);

  word_t     regs [RegCount];
  raddr_t    wait_reg;
  logic      waiting;
  out_item_t expected_q [$];

  function automatic out_item_t mk(action_t act, word_t x, word_t y, word_t z);
    out_item_t r;
    r.action    = act;
    r.operand_x = x;
    r.operand_y = y;
    r.operand_z = z;
    return r;
  endfunction

  task automatic execute(input in_item_t it);
    opcode_t   op;
    raddr_t    ra;
    raddr_t    rb_i;
    raddr_t    rc_i;
    word_t     vb;
    word_t     vc;
    logic [3:0] opc;
    out_item_t res;
    res = mk(ACT_NONE, '0, '0, '0);
    if (it.mode) begin
      if (waiting) begin
        regs[wait_reg] = it.response_value;
        waiting = 1'b0;
      end
    end else if (waiting) begin
      res = mk(ACT_REJECTED, '0, '0, '0);
    end else begin
      opc  = it.instr_word[31:28];
      op   = opcode_t'(opc);
      ra   = it.instr_word[8:6];
      rb_i = it.instr_word[5:3];
      rc_i = it.instr_word[2:0];
      vb   = regs[rb_i];
      vc   = regs[rc_i];
      if (opc > 4'd13) begin
        res = mk(ACT_ILLEGAL, '0, '0, '0);
      end else begin
        case (op)
          OP_CMOV: if (vc != 0) regs[ra] = vb;
          OP_LOAD: begin
            res = mk(ACT_LOAD, vb, vc, '0);
            wait_reg = ra;
            waiting = 1'b1;
          end
          OP_STORE: res = mk(ACT_STORE, regs[ra], vb, vc);
          OP_ADD:   regs[ra] = vb + vc;
          OP_MUL:   regs[ra] = vb * vc;
          OP_DIV: begin
            if (vc == 0) res = mk(ACT_DIVZERO, '0, '0, '0);
            else regs[ra] = vb / vc;
          end
          OP_NAND:  regs[ra] = ~(vb & vc);
          OP_HALT:  res = mk(ACT_HALT, '0, '0, '0);
          OP_MAP: begin
            res = mk(ACT_MAP, vc, '0, '0);
            wait_reg = rb_i;
            waiting = 1'b1;
          end
          OP_UNMAP: res = mk(ACT_UNMAP, vc, '0, '0);
          OP_OUT:   if (vc < CharLimit) res = mk(ACT_OUT, vc, '0, '0);
          OP_IN: begin
            res = mk(ACT_IN, '0, '0, '0);
            wait_reg = rc_i;
            waiting = 1'b1;
          end
          OP_PROG:  res = mk(ACT_PROG, vb, vc, '0);
          default:  regs[it.instr_word[27:25]] = {7'd0, it.instr_word[24:0]};
        endcase
      end
    end
    expected_q.push_back(res);
  endtask

  assign outstanding = expected_q.size();

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      foreach (regs[i]) regs[i] = '0;
      wait_reg = '0;
      waiting = 1'b0;
      expected_q.delete();
      errors <= 0;
    end else begin
      if (in_valid && in_ready) execute(in_item);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (e != out_item) begin
            $display("%0t: mismatch expected act=%0d x=%h y=%h z=%h actual act=%0d x=%h y=%h z=%h",
                     $time, e.action, e.operand_x, e.operand_y, e.operand_z,
                     out_item.action, out_item.operand_x, out_item.operand_y,
                     out_item.operand_z);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UM32 execute unit testbench
// Drives directed and random instruction and response items with random
// idling on both sides and one long output hold-off; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import um32_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   outstanding;
  int   cycles = 0;
  logic quiet = 1'b0;
  logic hold_off = 1'b0;

  um32_stream_if #(.payload_t(in_item_t))  in_ch ();
  um32_stream_if #(.payload_t(out_item_t)) out_ch ();

  um32_register_execute_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  um32_exec_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload),
    .errors(errors), .outstanding(outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stall bursts, long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic send(input logic m, input word_t w, input word_t r);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      n = $urandom_range(1, 11);
      repeat (n) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= {m, w, r};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic word_t ins(opcode_t op, int a, int b, int c);
    return {op, 19'd0, 3'(a), 3'(b), 3'(c)};
  endfunction

  function automatic word_t imm(int a, logic [24:0] v);
    return {OP_IMM, 3'(a), v};
  endfunction

  function automatic word_t rnd_word();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return word_t'($urandom_range(0, 300));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    word_t w;
    int k;
    k = $urandom_range(0, 19);
    if (k < 2) begin
      send(1'b1, $urandom, rnd_word());
    end else if (k < 4) begin
      send(1'b0, imm($urandom_range(0, 7), 25'($urandom_range(0, 300))), $urandom);
    end else if (k < 6) begin
      send(1'b0, imm($urandom_range(0, 7), 25'($urandom)), $urandom);
    end else begin
      w = $urandom;
      if (k < 18) w[31:28] = 4'($urandom_range(0, 13));
      send(1'b0, w, $urandom);
      if (w[31:28] inside {OP_LOAD, OP_MAP, OP_IN} && $urandom_range(0, 5) != 0)
        send(1'b1, $urandom, rnd_word());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed
    send(1'b1, '1, '1);
    send(1'b0, imm(1, '1), '0);
    send(1'b0, ins(OP_NAND, 2, 0, 0), '0);
    send(1'b0, ins(OP_ADD, 3, 2, 2), '0);
    send(1'b0, ins(OP_MUL, 4, 2, 2), '0);
    send(1'b0, ins(OP_DIV, 5, 2, 1), '0);
    send(1'b0, ins(OP_DIV, 5, 2, 0), '0);
    send(1'b0, ins(OP_CMOV, 6, 2, 0), '0);
    send(1'b0, ins(OP_CMOV, 6, 2, 1), '0);
    send(1'b0, ins(OP_STORE, 1, 2, 3), '0);
    send(1'b0, ins(OP_OUT, 0, 0, 2), '0);
    send(1'b0, imm(7, 25'd255), '0);
    send(1'b0, ins(OP_OUT, 0, 0, 7), '0);
    send(1'b0, ins(OP_UNMAP, 0, 0, 7), '0);
    send(1'b0, ins(OP_PROG, 0, 1, 7), '0);
    send(1'b0, ins(OP_HALT, 0, 0, 0), '0);
    send(1'b0, 32'hE000_0000, '0);
    send(1'b0, 32'hFFFF_FFFF, '0);
    send(1'b0, ins(OP_LOAD, 3, 1, 7), '0);
    send(1'b0, ins(OP_ADD, 0, 1, 1), '0);
    send(1'b1, '0, 32'h8000_0001);
    send(1'b0, ins(OP_MAP, 0, 4, 7), '0);
    send(1'b1, '0, 32'h0000_0003);
    send(1'b0, ins(OP_IN, 0, 0, 5), '0);
    send(1'b1, '0, '1);
    hold_off = 1'b1;
    for (int i = 0; i < 575; i++) begin
      if (i == 510) quiet = 1'b1;
      send_random();
    end
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/um32_pkg.sv
rtl/core/um32_stream_if.sv
rtl/core/um32_divider.sv
rtl/core/um32_register_execute_unit.sv
test/um32_exec_checker.sv
test/tb_top.sv
